/* hdl/bis_pkg.sv */
// Shared types and constants for the binary insertion sorter.
package bis_pkg;

    localparam int DATA_W           = 32;
    localparam int CAPACITY_DEFAULT = 16;

    typedef logic signed [DATA_W-1:0] value_t;

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } state_t;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctrl_t;

endpackage

/* hdl/bis_cell.sv */
// One cell of the sorting chain: holds a single stored value.
module bis_cell (
    input  logic               aclk,
    input  bis_pkg::value_t    key,
    input  bis_pkg::cell_ctrl_t ctrl,
    input  logic               valid,
    input  logic               prev_ins,
    input  bis_pkg::value_t    prev_value,
    input  bis_pkg::value_t    next_value,
    output logic               ins,
    output bis_pkg::value_t    value
);

    bis_pkg::value_t value_reg;
    bis_pkg::value_t value_next;

    // The key belongs at or before this cell when the cell is empty or holds a larger value.
    assign ins   = !valid || (key < value_reg);
    assign value = value_reg;

    always_comb begin
        value_next = value_reg;
        if (ctrl.shift) begin
            value_next = next_value;
        end else if (ctrl.insert && ins) begin
            // The first cell that opens up takes the key; the ones after it move up by one.
            value_next = prev_ins ? prev_value : key;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

/* hdl/binary_insertion_sorter_top.sv */
// Top level of the binary insertion sorter: cell chain, fill count and drain control.
//
// Values enter on the s_ channel at one transaction per cycle while s_tready is high and
// are placed in a chain of CAPACITY cells that all compare against the new value at once,
// so each value is sorted in the cycle it is accepted. The transaction with s_tlast high is
// inserted too, unless the store is full, and starts the drain: the set leaves on the m_
// channel in ascending order, one result per cycle while m_tready is high, taken straight
// from the first cell as the chain shifts down, with m_tlast on the final result and m_tuser
// high on every result of a set that lost values to a full store. During the drain s_tready
// is low, so the next set is accepted only after the last result of this set has left.
module binary_insertion_sorter_top #(
    parameter int CAPACITY = bis_pkg::CAPACITY_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] sort_value
    input  logic        s_tlast,   // is_last_item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] sorted_value
    output logic        m_tlast,   // is_last_result
    output logic [0:0]  m_tuser    // [0] overflowed
);

    localparam int COUNT_W = $clog2(CAPACITY + 1);

    bis_pkg::state_t    state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               overflow_reg, overflow_next;

    logic               in_fire;
    logic               out_fire;
    logic               full;
    bis_pkg::value_t    key;
    bis_pkg::cell_ctrl_t ctrl;

    logic               cell_ins   [CAPACITY];
    bis_pkg::value_t    cell_value [CAPACITY];

    assign key      = bis_pkg::value_t'(s_tdata);
    assign full     = (count_reg == COUNT_W'(CAPACITY));
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    assign ctrl.insert = in_fire && !full;
    assign ctrl.shift  = out_fire;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++) begin : g_cell
            logic            prev_ins;
            bis_pkg::value_t prev_value;
            bis_pkg::value_t next_value;

            if (i == 0) begin : g_first
                assign prev_ins   = 1'b0;
                assign prev_value = key;
            end else begin : g_inner
                assign prev_ins   = cell_ins[i-1];
                assign prev_value = cell_value[i-1];
            end

            if (i == CAPACITY - 1) begin : g_end
                assign next_value = cell_value[i];
            end else begin : g_mid
                assign next_value = cell_value[i+1];
            end

            bis_cell u_cell (
                .aclk       (aclk),
                .key        (key),
                .ctrl       (ctrl),
                .valid      (COUNT_W'(i) < count_reg),
                .prev_ins   (prev_ins),
                .prev_value (prev_value),
                .next_value (next_value),
                .ins        (cell_ins[i]),
                .value      (cell_value[i])
            );
        end
    endgenerate

    // Next state.
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;
        case (state_reg)
            bis_pkg::ST_FILL: begin
                if (in_fire) begin
                    if (full) begin
                        overflow_next = 1'b1;
                    end else begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                    if (s_tlast) begin
                        state_next = bis_pkg::ST_DRAIN;
                    end
                end
            end
            bis_pkg::ST_DRAIN: begin
                if (out_fire) begin
                    count_next = count_reg - COUNT_W'(1);
                    if (count_reg == COUNT_W'(1)) begin
                        state_next    = bis_pkg::ST_FILL;
                        overflow_next = 1'b0;
                    end
                end
            end
            default: begin
                state_next = bis_pkg::ST_FILL;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        case (state_reg)
            bis_pkg::ST_FILL:  s_tready = 1'b1;
            bis_pkg::ST_DRAIN: m_tvalid = 1'b1;
            default: begin
                s_tready = 1'b0;
                m_tvalid = 1'b0;
            end
        endcase
    end

    assign m_tdata    = cell_value[0];
    assign m_tlast    = (count_reg == COUNT_W'(1));
    assign m_tuser[0] = overflow_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= bis_pkg::ST_FILL;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
        end
    end

endmodule
